// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define PDJR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define PDJR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PDJR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/pdjr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdjr_pkg
// Widths, codes, pipeline types and helper functions of the Jacobian rows unit.
// ----------------------------------------------------------------------------
package pdjr_pkg;

  localparam int CoordW    = 24;
  localparam int DepthW    = 23;
  localparam int GiW       = 16;
  localparam int GdW       = 18;
  localparam int FocalW    = 20;
  localparam int JacW      = 32;
  localparam int NumRows   = 6;

  localparam int SqW       = 2 * CoordW;
  localparam int QuotW     = 39;
  localparam int DenW      = 2 * DepthW;
  localparam int NumW      = 64;
  localparam int MagW      = QuotW + 1;
  localparam int ProdW     = MagW + FocalW;
  localparam int SumW      = 60;

  localparam int NumLanes  = 8;
  localparam int LaneIz    = 0;
  localparam int LaneA     = 1;
  localparam int LaneB     = 2;
  localparam int LaneP     = 3;
  localparam int LaneQ     = 4;
  localparam int LaneXy    = 5;
  localparam int LaneXx    = 6;
  localparam int LaneYy    = 7;

  localparam int CfgIdxW   = 2;
  localparam logic [CfgIdxW-1:0] CfgFocalX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFocalY = 2'd1;
  localparam logic [FocalW-1:0]  FocalReset = 20'd134400;

  localparam int FocalShift = 8;
  localparam int IntShift   = 4;
  localparam int DepShift   = 16;

  localparam logic [MagW-1:0] MagSat  = {1'b0, {QuotW{1'b1}}};
  localparam logic [MagW-1:0] OneQ16  = 40'd65536;
  localparam logic signed [JacW-1:0] JacMax = 32'sh7FFF_FFFF;
  localparam logic signed [JacW-1:0] JacMin = 32'sh8000_0000;

  typedef struct packed {
    logic                  zero;
    logic                  sx;
    logic                  sy;
    logic signed [GiW-1:0] giu;
    logic signed [GiW-1:0] giv;
    logic signed [GdW-1:0] gdu;
    logic signed [GdW-1:0] gdv;
  } side_t;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QuotW-1:0] low;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic [DepthW-1:0]           z;
    logic [DenW-1:0]             z2;
    side_t                       side;
    lane_t [NumLanes-1:0]        lane;
  } divw_t;

  function automatic lane_t div_step(lane_t l, logic [DenW-1:0] den);
    logic [DenW:0] t;
    logic          qbit;
    lane_t         r;
    t    = {l.rem, l.low[QuotW-1]};
    qbit = (t >= {1'b0, den});
    if (qbit) begin
      t = t - {1'b0, den};
    end
    r.rem = t[DenW-1:0];
    r.low = {l.low[QuotW-2:0], qbit};
    r.ovf = l.ovf;
    return r;
  endfunction

  function automatic logic signed [MagW-1:0] focal_round(logic [ProdW-1:0] p, logic neg);
    logic [ProdW-1:0] r;
    logic [MagW-1:0]  m;
    r = (p + (ProdW'(1) << (FocalShift - 1))) >> FocalShift;
    m = (r > ProdW'(MagSat)) ? MagSat : r[MagW-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [JacW-1:0] round_sat(logic signed [SumW-1:0] v,
                                                       logic [4:0] sh);
    logic [SumW-1:0] mag;
    logic [SumW-1:0] q;
    logic [SumW-1:0] lim;
    mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
    q   = (mag + (SumW'(1) << (sh - 5'd1))) >> sh;
    lim = SumW'(1) << (JacW - 1);
    if (v[SumW-1]) begin
      return (q >= lim) ? JacMin : -$signed(q[JacW-1:0]);
    end
    return (q >= lim) ? JacMax : $signed(q[JacW-1:0]);
  endfunction

endpackage

// ----- rtl/pdjr_point_if.sv -----
// ----------------------------------------------------------------------------
// pdjr_point_if
// Request channel carrying one camera-frame point and its gradients.
// ----------------------------------------------------------------------------
interface pdjr_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdjr_pkg::CoordW-1:0]    point_x;
  logic signed [pdjr_pkg::CoordW-1:0]    point_y;
  logic        [pdjr_pkg::DepthW-1:0]    point_z;
  logic signed [pdjr_pkg::GiW-1:0]       grad_intensity_u;
  logic signed [pdjr_pkg::GiW-1:0]       grad_intensity_v;
  logic signed [pdjr_pkg::GdW-1:0]       grad_depth_u;
  logic signed [pdjr_pkg::GdW-1:0]       grad_depth_v;

  modport source (output valid, point_x, point_y, point_z, grad_intensity_u,
                  grad_intensity_v, grad_depth_u, grad_depth_v, input ready);
  modport sink   (input valid, point_x, point_y, point_z, grad_intensity_u,
                  grad_intensity_v, grad_depth_u, grad_depth_v, output ready);
endinterface

// ----- rtl/pdjr_rows_if.sv -----
// ----------------------------------------------------------------------------
// pdjr_rows_if
// Result channel carrying the intensity and depth Jacobian rows.
// ----------------------------------------------------------------------------
interface pdjr_rows_if;
  logic                               valid;
  logic                               ready;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_0;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_1;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_2;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_3;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_4;
  logic signed [pdjr_pkg::JacW-1:0]   int_jac_5;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_0;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_1;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_2;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_3;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_4;
  logic signed [pdjr_pkg::JacW-1:0]   dep_jac_5;

  modport source (output valid, int_jac_0, int_jac_1, int_jac_2, int_jac_3, int_jac_4,
                  int_jac_5, dep_jac_0, dep_jac_1, dep_jac_2, dep_jac_3, dep_jac_4,
                  dep_jac_5, input ready);
  modport sink   (input valid, int_jac_0, int_jac_1, int_jac_2, int_jac_3, int_jac_4,
                  int_jac_5, dep_jac_0, dep_jac_1, dep_jac_2, dep_jac_3, dep_jac_4,
                  dep_jac_5, output ready);
endinterface

// ----- rtl/pdjr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pdjr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pdjr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pdjr_pkg::CfgIdxW-1:0]       index;
  logic [pdjr_pkg::FocalW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pdjr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pdjr_cfg_regs
// Focal length registers written through the configuration channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdjr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pdjr_cfg_if.sink                      cfg_i,
  output logic [pdjr_pkg::FocalW-1:0]   fx_o,
  output logic [pdjr_pkg::FocalW-1:0]   fy_o
);

  logic [pdjr_pkg::FocalW-1:0] fx_q, fx_d;
  logic [pdjr_pkg::FocalW-1:0] fy_q, fy_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    fx_d = fx_q;
    fy_d = fy_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pdjr_pkg::CfgFocalX: fx_d = cfg_i.data;
        pdjr_pkg::CfgFocalY: fy_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= pdjr_pkg::FocalReset;
      fy_q <= pdjr_pkg::FocalReset;
    end else begin
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
  end

  assign fx_o = fx_q;
  assign fy_o = fy_q;

  `PDJR_ASSERT_NEXT(a_fx_write, cfg_i.valid && cfg_i.ready && cfg_i.index == pdjr_pkg::CfgFocalX, fx_q == $past(cfg_i.data), "focal_x write lost")
  `PDJR_ASSERT_NEXT(a_fy_write, cfg_i.valid && cfg_i.ready && cfg_i.index == pdjr_pkg::CfgFocalY, fy_q == $past(cfg_i.data), "focal_y write lost")

endmodule

// ----- rtl/pdjr_front.sv -----
// ----------------------------------------------------------------------------
// pdjr_front
// Input register, magnitudes and squares, and divider numerator set-up.
// ----------------------------------------------------------------------------
module pdjr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  pdjr_point_if.sink       in_i,
  output pdjr_pkg::divw_t  stage_o,
  output logic             valid_o
);

  logic signed [pdjr_pkg::CoordW-1:0] x0_q, y0_q;
  logic        [pdjr_pkg::DepthW-1:0] z0_q;
  logic signed [pdjr_pkg::GiW-1:0]    giu0_q, giv0_q;
  logic signed [pdjr_pkg::GdW-1:0]    gdu0_q, gdv0_q;
  logic                               v0_q, v1_q, v2_q;

  logic [pdjr_pkg::CoordW-1:0] ax_d, ay_d, ax_q, ay_q;
  logic [pdjr_pkg::DepthW-1:0] z1_q;
  logic [pdjr_pkg::DenW-1:0]   z2_d, z2_q;
  logic [pdjr_pkg::SqW-1:0]    xy_d, xx_d, yy_d, xy_q, xx_q, yy_q;
  pdjr_pkg::side_t             side1_d, side1_q;

  logic [pdjr_pkg::NumW-1:0]   num [pdjr_pkg::NumLanes];
  logic [pdjr_pkg::DenW-1:0]   den [pdjr_pkg::NumLanes];
  logic [pdjr_pkg::NumW-1:0]   mp  [pdjr_pkg::NumLanes];
  pdjr_pkg::divw_t             st_d, st_q;

  assign in_i.ready = en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= in_i.point_x;
      y0_q   <= in_i.point_y;
      z0_q   <= in_i.point_z;
      giu0_q <= in_i.grad_intensity_u;
      giv0_q <= in_i.grad_intensity_v;
      gdu0_q <= in_i.grad_depth_u;
      gdv0_q <= in_i.grad_depth_v;
    end
  end

  always_comb begin
    ax_d = x0_q[pdjr_pkg::CoordW-1] ? pdjr_pkg::CoordW'(-x0_q) : pdjr_pkg::CoordW'(x0_q);
    ay_d = y0_q[pdjr_pkg::CoordW-1] ? pdjr_pkg::CoordW'(-y0_q) : pdjr_pkg::CoordW'(y0_q);
    z2_d = pdjr_pkg::DenW'(z0_q) * pdjr_pkg::DenW'(z0_q);
    xy_d = pdjr_pkg::SqW'(ax_d) * pdjr_pkg::SqW'(ay_d);
    xx_d = pdjr_pkg::SqW'(ax_d) * pdjr_pkg::SqW'(ax_d);
    yy_d = pdjr_pkg::SqW'(ay_d) * pdjr_pkg::SqW'(ay_d);
    side1_d.zero = (z0_q == '0);
    side1_d.sx   = x0_q[pdjr_pkg::CoordW-1];
    side1_d.sy   = y0_q[pdjr_pkg::CoordW-1];
    side1_d.giu  = giu0_q;
    side1_d.giv  = giv0_q;
    side1_d.gdu  = gdu0_q;
    side1_d.gdv  = gdv0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      z1_q    <= z0_q;
      z2_q    <= z2_d;
      xy_q    <= xy_d;
      xx_q    <= xx_d;
      yy_q    <= yy_d;
      side1_q <= side1_d;
    end
  end

  always_comb begin
    num[pdjr_pkg::LaneIz] = pdjr_pkg::NumW'(1) << 32;
    num[pdjr_pkg::LaneA]  = pdjr_pkg::NumW'(ax_q) << 16;
    num[pdjr_pkg::LaneB]  = pdjr_pkg::NumW'(ay_q) << 16;
    num[pdjr_pkg::LaneP]  = pdjr_pkg::NumW'(ax_q) << 32;
    num[pdjr_pkg::LaneQ]  = pdjr_pkg::NumW'(ay_q) << 32;
    num[pdjr_pkg::LaneXy] = pdjr_pkg::NumW'(xy_q) << 16;
    num[pdjr_pkg::LaneXx] = pdjr_pkg::NumW'(xx_q) << 16;
    num[pdjr_pkg::LaneYy] = pdjr_pkg::NumW'(yy_q) << 16;
    st_d.z    = z1_q;
    st_d.z2   = z2_q;
    st_d.side = side1_q;
    for (int k = 0; k < pdjr_pkg::NumLanes; k++) begin
      den[k] = (k <= pdjr_pkg::LaneB) ? pdjr_pkg::DenW'(z1_q) : z2_q;
      mp[k]  = num[k] + pdjr_pkg::NumW'(den[k] >> 1);
      st_d.lane[k].rem = pdjr_pkg::DenW'(mp[k][pdjr_pkg::NumW-1:pdjr_pkg::QuotW]);
      st_d.lane[k].low = mp[k][pdjr_pkg::QuotW-1:0];
      st_d.lane[k].ovf = pdjr_pkg::DenW'(mp[k][pdjr_pkg::NumW-1:pdjr_pkg::QuotW]) >= den[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;
  assign valid_o = v2_q;

endmodule

// ----- rtl/pdjr_div_array.sv -----
// ----------------------------------------------------------------------------
// pdjr_div_array
// Eight pipelined restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdjr_div_array (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pdjr_pkg::divw_t  stage_i,
  input  logic             valid_i,
  output pdjr_pkg::divw_t  stage_o,
  output logic             valid_o
);

  pdjr_pkg::divw_t            src   [pdjr_pkg::QuotW];
  pdjr_pkg::divw_t            nxt   [pdjr_pkg::QuotW];
  pdjr_pkg::divw_t            st_q  [pdjr_pkg::QuotW];
  logic [pdjr_pkg::QuotW-1:0] vld_q;
  logic [pdjr_pkg::DenW-1:0]  last_den [pdjr_pkg::NumLanes];

  always_comb begin
    src[0] = stage_i;
    for (int i = 1; i < pdjr_pkg::QuotW; i++) begin
      src[i] = st_q[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < pdjr_pkg::QuotW; i++) begin
      nxt[i] = src[i];
      for (int k = 0; k < pdjr_pkg::NumLanes; k++) begin
        nxt[i].lane[k] = pdjr_pkg::div_step(src[i].lane[k],
          (k <= pdjr_pkg::LaneB) ? pdjr_pkg::DenW'(src[i].z) : src[i].z2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[pdjr_pkg::QuotW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < pdjr_pkg::QuotW; i++) begin
        st_q[i] <= nxt[i];
      end
    end
  end

  assign stage_o = st_q[pdjr_pkg::QuotW-1];
  assign valid_o = vld_q[pdjr_pkg::QuotW-1];

  always_comb begin
    for (int k = 0; k < pdjr_pkg::NumLanes; k++) begin
      last_den[k] = (k <= pdjr_pkg::LaneB) ? pdjr_pkg::DenW'(stage_o.z) : stage_o.z2;
    end
  end

  for (genvar k = 0; k < pdjr_pkg::NumLanes; k++) begin : g_chk
    `PDJR_ASSERT(a_rem_bound, valid_o && !stage_o.side.zero && !stage_o.lane[k].ovf |-> stage_o.lane[k].rem < last_den[k], "divider remainder out of range")
  end

endmodule

// ----- rtl/pdjr_back.sv -----
// ----------------------------------------------------------------------------
// pdjr_back
// Saturation, focal scaling, gradient weighting and the output register.
// ----------------------------------------------------------------------------
module pdjr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pdjr_pkg::FocalW-1:0]   fx_i,
  input  logic [pdjr_pkg::FocalW-1:0]   fy_i,
  input  pdjr_pkg::divw_t               stage_i,
  input  logic                          valid_i,
  pdjr_rows_if.source                   out_o,
  output logic                          en_o
);

  localparam int NR = pdjr_pkg::NumRows;

  logic [5:0]                      vb_q;
  pdjr_pkg::side_t                 side_q [5];

  logic [pdjr_pkg::MagW-1:0]       mag_d [pdjr_pkg::NumLanes];
  logic [pdjr_pkg::MagW-1:0]       mag_q [pdjr_pkg::NumLanes];
  logic [pdjr_pkg::ProdW-1:0]      pu_d [NR], pv_d [NR], pu_q [NR], pv_q [NR];
  logic [NR-1:0]                   negu_d, negv_d, negu_q, negv_q;
  logic signed [pdjr_pkg::MagW-1:0] u_q [NR], v_q [NR];
  logic signed [pdjr_pkg::SumW-1:0] piu_q [NR], piv_q [NR], pdu_q [NR], pdv_q [NR];
  logic signed [pdjr_pkg::SumW-1:0] si_q [NR], sd_q [NR];
  logic signed [pdjr_pkg::JacW-1:0] ij_q [NR], dj_q [NR];
  logic                            sx, sy;

  assign en_o        = !vb_q[5] || out_o.ready;
  assign out_o.valid = vb_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en_o) begin
      vb_q <= {vb_q[4:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < pdjr_pkg::NumLanes; k++) begin
      if (k == pdjr_pkg::LaneXx || k == pdjr_pkg::LaneYy) begin
        mag_d[k] = (stage_i.lane[k].ovf || (pdjr_pkg::MagW'(stage_i.lane[k].low)
                   + pdjr_pkg::OneQ16) > pdjr_pkg::MagSat) ? pdjr_pkg::MagSat
                   : pdjr_pkg::MagW'(stage_i.lane[k].low) + pdjr_pkg::OneQ16;
      end else begin
        mag_d[k] = stage_i.lane[k].ovf ? pdjr_pkg::MagSat
                   : pdjr_pkg::MagW'(stage_i.lane[k].low);
      end
    end
  end

  always_comb begin
    sx = side_q[0].sx;
    sy = side_q[0].sy;
    pu_d[0] = pdjr_pkg::ProdW'(fx_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneIz]);
    pu_d[1] = '0;
    pu_d[2] = pdjr_pkg::ProdW'(fx_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneP]);
    pu_d[3] = pdjr_pkg::ProdW'(fx_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneXy]);
    pu_d[4] = pdjr_pkg::ProdW'(fx_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneXx]);
    pu_d[5] = pdjr_pkg::ProdW'(fx_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneB]);
    pv_d[0] = '0;
    pv_d[1] = pdjr_pkg::ProdW'(fy_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneIz]);
    pv_d[2] = pdjr_pkg::ProdW'(fy_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneQ]);
    pv_d[3] = pdjr_pkg::ProdW'(fy_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneYy]);
    pv_d[4] = pdjr_pkg::ProdW'(fy_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneXy]);
    pv_d[5] = pdjr_pkg::ProdW'(fy_i) * pdjr_pkg::ProdW'(mag_q[pdjr_pkg::LaneA]);
    negu_d  = {!sy, 1'b0, !(sx ^ sy), !sx, 1'b0, 1'b0};
    negv_d  = {sx, sx ^ sy, 1'b1, !sy, 1'b0, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      side_q[0] <= stage_i.side;
      for (int s = 1; s < 5; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int k = 0; k < pdjr_pkg::NumLanes; k++) begin
        mag_q[k] <= mag_d[k];
      end
      negu_q <= negu_d;
      negv_q <= negv_d;
      for (int k = 0; k < NR; k++) begin
        pu_q[k]  <= pu_d[k];
        pv_q[k]  <= pv_d[k];
        u_q[k]   <= pdjr_pkg::focal_round(pu_q[k], negu_q[k]);
        v_q[k]   <= pdjr_pkg::focal_round(pv_q[k], negv_q[k]);
        piu_q[k] <= pdjr_pkg::SumW'(side_q[2].giu) * pdjr_pkg::SumW'(u_q[k]);
        piv_q[k] <= pdjr_pkg::SumW'(side_q[2].giv) * pdjr_pkg::SumW'(v_q[k]);
        pdu_q[k] <= pdjr_pkg::SumW'(side_q[2].gdu) * pdjr_pkg::SumW'(u_q[k]);
        pdv_q[k] <= pdjr_pkg::SumW'(side_q[2].gdv) * pdjr_pkg::SumW'(v_q[k]);
        si_q[k]  <= piu_q[k] + piv_q[k];
        sd_q[k]  <= pdu_q[k] + pdv_q[k];
        ij_q[k]  <= side_q[4].zero ? pdjr_pkg::JacMax
                    : pdjr_pkg::round_sat(si_q[k], 5'(pdjr_pkg::IntShift));
        dj_q[k]  <= side_q[4].zero ? pdjr_pkg::JacMax
                    : pdjr_pkg::round_sat(sd_q[k], 5'(pdjr_pkg::DepShift));
      end
    end
  end

  assign out_o.int_jac_0 = ij_q[0];
  assign out_o.int_jac_1 = ij_q[1];
  assign out_o.int_jac_2 = ij_q[2];
  assign out_o.int_jac_3 = ij_q[3];
  assign out_o.int_jac_4 = ij_q[4];
  assign out_o.int_jac_5 = ij_q[5];
  assign out_o.dep_jac_0 = dj_q[0];
  assign out_o.dep_jac_1 = dj_q[1];
  assign out_o.dep_jac_2 = dj_q[2];
  assign out_o.dep_jac_3 = dj_q[3];
  assign out_o.dep_jac_4 = dj_q[4];
  assign out_o.dep_jac_5 = dj_q[5];

endmodule

// ----- rtl/photometric_depth_jacobian_rows_unit.sv -----
// ----------------------------------------------------------------------------
// photometric_depth_jacobian_rows_unit
// Pinhole projection Jacobian rows weighted by intensity and depth gradients.
// ----------------------------------------------------------------------------
// The in_i channel takes one camera-frame point with its intensity and depth
// gradients per request; the out_o channel returns the six-entry intensity row
// and the six-entry depth row for it, in order, one result per request.
// The cfg_i channel writes focal_x (index 0) and focal_y (index 1); it is
// always ready and should only be used while no request is in flight.
// From acceptance to a valid result a request passes three set-up stages,
// 39 divider stages (one quotient bit per stage for eight parallel dividers)
// and six stages of saturation, focal scaling and gradient weighting.
// Throughput is one request per cycle unless stalled; dividers set the depth.
// All stages advance together: when the receiver holds ready low with a result
// waiting, the whole pipeline holds and in_i.ready falls in the same cycle.
// Reset clears all valid bits and loads both focal lengths with 525 pixels.
// A point at zero depth returns 0x7FFFFFFF in every entry.
// ----------------------------------------------------------------------------
module photometric_depth_jacobian_rows_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdjr_point_if.sink    in_i,
  pdjr_rows_if.source   out_o,
  pdjr_cfg_if.sink      cfg_i
);

  logic [pdjr_pkg::FocalW-1:0] fx, fy;
  logic                        en;
  pdjr_pkg::divw_t             front_stage, div_stage;
  logic                        front_valid, div_valid;

  pdjr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .fx_o   (fx),
    .fy_o   (fy)
  );

  pdjr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (in_i),
    .stage_o (front_stage),
    .valid_o (front_valid)
  );

  pdjr_div_array u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (front_stage),
    .valid_i (front_valid),
    .stage_o (div_stage),
    .valid_o (div_valid)
  );

  pdjr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fx_i    (fx),
    .fy_i    (fy),
    .stage_i (div_stage),
    .valid_i (div_valid),
    .out_o   (out_o),
    .en_o    (en)
  );

endmodule
